// ----- rtl/core/ofc_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, controller states and command/status types of the filtration cascade
package ofc_pkg;

    localparam int SMP_W     = 16;
    localparam int STG_W     = 24;
    localparam int FRAC_W    = 8;
    localparam int CNT_W     = 32;
    localparam int LVL_W     = 5;
    localparam int IG_W      = 17;
    localparam int F_W       = IG_W + CNT_W;
    localparam int DEN_W     = 50;
    localparam int NUMLO_W   = 33;
    localparam int G_W       = 33;
    localparam int DIFF_W    = STG_W + 1;
    localparam int PROD_W    = DIFF_W + G_W + 1;
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = IG_W;

    localparam logic [CFG_IDX_W-1:0] REG_LEVELS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_GAIN = 1'b1;

    localparam logic [LVL_W-1:0] LEVELS_RESET   = 5'd4;
    localparam logic [IG_W-1:0]  INV_GAIN_RESET = 17'd12400;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SEED,
        ST_DIV,
        ST_ST0,
        ST_MULT,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic seed_wr;
        logic div_init;
        logic div_step;
        logic st0;
        logic mult;
        logic upd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic seed;
        logic last;
    } t_sts;

endpackage

// ----- rtl/core/ofc_ctrl.sv -----
`timescale 1ns / 1ps
// controller state machine sequencing seed, reciprocal divide and per-stage update
module ofc_ctrl #(
    parameter int MAX_LEVELS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    input  ofc_pkg::t_sts                           i_sts,
    output ofc_pkg::t_cmd                           o_cmd,
    output logic [$clog2(MAX_LEVELS+1)-1:0]         o_idx
);

    localparam int IW = $clog2(MAX_LEVELS + 1);

    ofc_pkg::t_state                   r_state, n_state;
    logic [IW-1:0]                     r_idx, n_idx;
    logic [ofc_pkg::DIV_CNT_W-1:0]     r_dcnt, n_dcnt;
    logic                              r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ofc_pkg::ST_IDLE;
            r_idx    <= '0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_dcnt   <= n_dcnt;
            r_ovalid <= n_ovalid;
        end
    end

    // next state and counters
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_dcnt   = r_dcnt;
        n_ovalid = r_ovalid && !i_out_ready;
        unique case (r_state)
            ofc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ofc_pkg::ST_SETUP;
                    n_idx   = '0;
                    n_dcnt  = '0;
                end
            end
            ofc_pkg::ST_SETUP: begin
                n_state = i_sts.seed ? ofc_pkg::ST_SEED : ofc_pkg::ST_DIV;
            end
            ofc_pkg::ST_SEED: begin
                if (i_sts.last) begin
                    n_state = ofc_pkg::ST_DONE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            ofc_pkg::ST_DIV: begin
                n_dcnt = r_dcnt + ofc_pkg::DIV_CNT_W'(1);
                if (r_dcnt == ofc_pkg::DIV_CNT_W'(ofc_pkg::DIV_STEPS - 1)) begin
                    n_state = ofc_pkg::ST_ST0;
                end
            end
            ofc_pkg::ST_ST0: begin
                if (i_sts.last) begin
                    n_state = ofc_pkg::ST_DONE;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = ofc_pkg::ST_MULT;
                end
            end
            ofc_pkg::ST_MULT: begin
                n_state = ofc_pkg::ST_UPD;
            end
            ofc_pkg::ST_UPD: begin
                if (i_sts.last) begin
                    n_state = ofc_pkg::ST_DONE;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = ofc_pkg::ST_MULT;
                end
            end
            ofc_pkg::ST_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    n_state  = ofc_pkg::ST_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_state = ofc_pkg::ST_IDLE;
            end
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ofc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ofc_pkg::ST_SETUP: o_cmd.div_init = !i_sts.seed;
            ofc_pkg::ST_SEED:  o_cmd.seed_wr  = 1'b1;
            ofc_pkg::ST_DIV:   o_cmd.div_step = 1'b1;
            ofc_pkg::ST_ST0:   o_cmd.st0      = 1'b1;
            ofc_pkg::ST_MULT:  o_cmd.mult     = 1'b1;
            ofc_pkg::ST_UPD:   o_cmd.upd      = 1'b1;
            ofc_pkg::ST_DONE:  o_cmd.out_load = !r_ovalid || i_out_ready;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_idx       = r_idx;
    assign o_out_valid = r_ovalid;

endmodule

// ----- rtl/core/ofc_dpath.sv -----
`timescale 1ns / 1ps
// datapath: config registers, sample count, serial reciprocal divider, stage memory, mixer
module ofc_dpath #(
    parameter int MAX_LEVELS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ofc_pkg::t_cmd                           i_cmd,
    input  logic [$clog2(MAX_LEVELS+1)-1:0]         i_idx,
    output ofc_pkg::t_sts                           o_sts,
    input  logic [ofc_pkg::SMP_W-1:0]               i_sample,
    input  logic                                    i_restart,
    input  logic                                    i_cfg_valid,
    input  logic [ofc_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [ofc_pkg::CFG_DAT_W-1:0]           i_cfg_data,
    output logic [ofc_pkg::SMP_W-1:0]               o_filtered
);

    localparam int IW    = $clog2(MAX_LEVELS + 1);
    localparam int DEPTH = MAX_LEVELS + 1;

    logic [ofc_pkg::LVL_W-1:0]     r_levels;
    logic [ofc_pkg::IG_W-1:0]      r_inv_gain;
    logic [ofc_pkg::CNT_W-1:0]     r_count;
    logic                          r_seed;
    logic [ofc_pkg::SMP_W-1:0]     r_smp;
    logic [ofc_pkg::DEN_W-1:0]     r_den;
    logic [ofc_pkg::DEN_W-1:0]     r_rem;
    logic [ofc_pkg::NUMLO_W-1:0]   r_numlo;
    logic [ofc_pkg::G_W-1:0]       r_quo;
    logic [ofc_pkg::STG_W-1:0]     r_prev;
    logic [ofc_pkg::STG_W-1:0]     r_cur;
    logic signed [ofc_pkg::PROD_W-1:0] r_prod;
    logic [ofc_pkg::STG_W-1:0]     r_mem [DEPTH];
    logic [DEPTH-1:0]              r_valid;
    logic [ofc_pkg::STG_W-1:0]     r_rd_data;
    logic                          r_rd_valid;
    logic [ofc_pkg::SMP_W-1:0]     r_filtered;

    logic [IW-1:0]                 w_n;
    logic [ofc_pkg::CNT_W-1:0]     w_eff;
    logic [ofc_pkg::F_W-1:0]       w_f;
    logic [ofc_pkg::DEN_W-1:0]     w_num;
    logic [ofc_pkg::DEN_W:0]       w_rem_sh;
    logic                          w_ge;
    logic [ofc_pkg::STG_W-1:0]     w_seed_val;
    logic [ofc_pkg::STG_W-1:0]     w_cur;
    logic [ofc_pkg::DIFF_W-1:0]    w_diff;
    logic [ofc_pkg::PROD_W-1:0]    w_rnd;
    logic [ofc_pkg::STG_W-1:0]     w_new;
    logic                          w_we;
    logic [ofc_pkg::STG_W-1:0]     w_wdata;
    logic                          w_re;
    logic [IW-1:0]                 w_rd_addr;
    logic [ofc_pkg::DIFF_W-1:0]    w_rq;
    logic [ofc_pkg::SMP_W:0]       w_q;

    // levels above the cascade depth behave as the full depth
    always_comb begin
        if (32'(r_levels) > MAX_LEVELS) begin
            w_n = IW'(MAX_LEVELS);
        end else begin
            w_n = IW'(r_levels);
        end
    end

    assign o_sts.seed = r_seed;
    assign o_sts.last = (i_idx == w_n);

    assign w_eff = i_restart ? '0 : r_count;
    assign w_f   = ofc_pkg::F_W'(r_inv_gain) * ofc_pkg::F_W'(w_eff);

    // numerator 2^48 + d/2 for a rounded reciprocal
    assign w_num    = (ofc_pkg::DEN_W'(1) << 48) + (r_den >> 1);
    assign w_rem_sh = {r_rem, r_numlo[ofc_pkg::NUMLO_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});

    assign w_seed_val = {r_smp, {ofc_pkg::FRAC_W{1'b0}}};
    assign w_cur      = r_rd_valid ? r_rd_data : '0;
    assign w_diff     = {r_prev[ofc_pkg::STG_W-1], r_prev} - {w_cur[ofc_pkg::STG_W-1], w_cur};
    assign w_rnd      = r_prod + ofc_pkg::PROD_W'(64'h8000_0000);
    assign w_new      = r_cur + w_rnd[32 +: ofc_pkg::STG_W];

    assign w_we      = i_cmd.seed_wr || i_cmd.st0 || i_cmd.upd;
    assign w_wdata   = i_cmd.upd ? w_new : w_seed_val;
    assign w_re      = i_cmd.st0 || i_cmd.upd;
    assign w_rd_addr = o_sts.last ? i_idx : i_idx + IW'(1);

    assign w_rq = {r_prev[ofc_pkg::STG_W-1], r_prev} + ofc_pkg::DIFF_W'(128);
    assign w_q  = w_rq[ofc_pkg::DIFF_W-1:ofc_pkg::FRAC_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels   <= ofc_pkg::LEVELS_RESET;
            r_inv_gain <= ofc_pkg::INV_GAIN_RESET;
            r_count    <= '0;
            r_seed     <= 1'b0;
            r_valid    <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    ofc_pkg::REG_LEVELS:   r_levels   <= i_cfg_data[ofc_pkg::LVL_W-1:0];
                    ofc_pkg::REG_INV_GAIN: r_inv_gain <= i_cfg_data;
                    default: begin
                        r_levels <= r_levels;
                    end
                endcase
            end
            if (i_cmd.load) begin
                r_seed  <= (w_eff == '0);
                r_count <= (w_eff == '1) ? w_eff : w_eff + ofc_pkg::CNT_W'(1);
            end
            if (w_we) begin
                r_valid[i_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_smp <= i_sample;
            r_den <= ofc_pkg::DEN_W'(65536) + ofc_pkg::DEN_W'(w_f);
        end
        if (i_cmd.div_init) begin
            r_rem   <= ofc_pkg::DEN_W'(w_num[ofc_pkg::DEN_W-1:ofc_pkg::NUMLO_W]);
            r_numlo <= w_num[ofc_pkg::NUMLO_W-1:0];
            r_quo   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem   <= w_ge ? ofc_pkg::DEN_W'(w_rem_sh - {1'b0, r_den})
                            : w_rem_sh[ofc_pkg::DEN_W-1:0];
            r_numlo <= {r_numlo[ofc_pkg::NUMLO_W-2:0], 1'b0};
            r_quo   <= {r_quo[ofc_pkg::G_W-2:0], w_ge};
        end
        if (i_cmd.seed_wr || i_cmd.st0) begin
            r_prev <= w_seed_val;
        end else if (i_cmd.upd) begin
            r_prev <= w_new;
        end
        if (i_cmd.mult) begin
            r_prod <= $signed(w_diff) * $signed({1'b0, r_quo});
            r_cur  <= w_cur;
        end
        if (i_cmd.out_load) begin
            // a stage just under the top would round one past the largest code
            r_filtered <= (w_q[ofc_pkg::SMP_W:ofc_pkg::SMP_W-1] == 2'b01)
                          ? 16'h7FFF : w_q[ofc_pkg::SMP_W-1:0];
        end
    end

    // stage memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[i_idx] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data  <= r_mem[w_rd_addr];
            r_rd_valid <= r_valid[w_rd_addr];
        end
    end

    assign o_filtered = r_filtered;

endmodule

// ----- rtl/core/optimal_filtration_cascade.sv -----
`timescale 1ns / 1ps
// top level of the cascaded optimal-filtration smoother
// One item at a time. The first sample after reset or restart seeds stages 0..n: after the
// setup state come n+1 seed writes and the load of the output register. Any later sample
// passes the setup state, the bit-serial divider that forms the rounded reciprocal gain,
// the stage 0 write, then a multiply and a round and write-back per stage through the
// single read and write port of the stage memory, and the load of the output register.
// n is levels, capped at MAX_LEVELS. The next sample can be taken from the cycle after the
// result is placed in the output register, even if that result is still waiting to be
// taken.
// Stage reset values come from per-entry valid bits, so no clearing pass runs after reset.
// The configuration port is always ready.
module optimal_filtration_cascade #(
    parameter int MAX_LEVELS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [15:0]                       i_s_axis_tdata,   // [15:0] sample
    input  logic                              i_s_axis_tuser,   // [0] restart
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [15:0]                       o_m_axis_tdata,   // [15:0] filtered
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ofc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ofc_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    localparam int IW = $clog2(MAX_LEVELS + 1);

    ofc_pkg::t_cmd  w_cmd;
    ofc_pkg::t_sts  w_sts;
    logic [IW-1:0]  w_idx;

    assign o_cfg_ready = 1'b1;

    ofc_ctrl #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_idx       (w_idx)
    );

    ofc_dpath #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_idx       (w_idx),
        .o_sts       (w_sts),
        .i_sample    (i_s_axis_tdata),
        .i_restart   (i_s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_filtered  (o_m_axis_tdata)
    );

    // a pending result is never overwritten
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("result register loaded while a result is pending");

    // no new request while an item is in the datapath
    a_busy_not_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !o_s_axis_tready)
        else $error("input ready right after a request was taken");

    // at most one datapath command per cycle
    a_one_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command in a cycle");

    // stage updates only follow a multiply in the previous cycle
    a_upd_after_mult : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.upd |-> $past(w_cmd.mult))
        else $error("stage update without a preceding multiply");

endmodule

// ----- tb/sv/tb_optimal_filtration_cascade.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the filtration cascade: stream traffic, register writes, mirrored model
module tb_optimal_filtration_cascade;

    localparam int  MAX_LVL       = 16;
    localparam int  IDLE_MAX      = 16;
    localparam int  SETTLE_CYCLES = 80;     // longer than the longest item at n = 16
    localparam int  RX_HOLD       = 400;
    localparam real RUN_LIMIT_NS  = 5.0e6;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_tvalid;
    logic [15:0]                   s_tdata;          // [15:0] sample
    logic                          s_tuser;          // [0] restart
    logic                          m_tready;
    logic                          cfg_valid;
    logic [ofc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ofc_pkg::CFG_DAT_W-1:0] cfg_data;
    wire                           o_s_axis_tready;
    wire                           o_m_axis_tvalid;
    wire  [15:0]                   o_m_axis_tdata;   // [15:0] filtered
    wire                           o_cfg_ready;

    optimal_filtration_cascade #(
        .MAX_LEVELS(MAX_LVL)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // mirrored block state and registers
    logic [ofc_pkg::STG_W-1:0] stage_mirror [0:MAX_LVL];
    logic [ofc_pkg::CNT_W-1:0] count_mirror;
    logic [ofc_pkg::LVL_W-1:0] levels_reg;
    logic [ofc_pkg::IG_W-1:0]  inv_gain_reg;

    logic [15:0] expected_filtered [$];
    int          samples_sent;
    int          results_checked;
    int          reg_writes;
    int          error_count;
    int          tx_mode;   // 0: back to back, 1: full random gaps, 2: rare gaps
    int          rx_mode;
    bit          rx_hold_req;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_gap(input int mode);
        case (mode)
            0: draw_gap = 0;
            1: draw_gap = $urandom_range(0, IDLE_MAX);
            default: draw_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, IDLE_MAX) : 0;
        endcase
    endfunction

    // stage values are kept offset by half range, which turns the mix into unsigned math
    function automatic logic [63:0] to_offset(input logic [ofc_pkg::STG_W-1:0] v);
        to_offset = {40'd0, v ^ 24'h800000};
    endfunction

    function automatic logic [15:0] cascade_predict(input logic [15:0] smp, input logic rst_cnt);
        int          n;
        logic [63:0] f;
        logic [63:0] d;
        logic [63:0] g;
        logic [63:0] gc;
        logic [63:0] mix;
        logic [63:0] r;
        n = (levels_reg > MAX_LVL) ? MAX_LVL : int'(levels_reg);
        if (rst_cnt) begin
            count_mirror = '0;
        end
        if (count_mirror == '0) begin
            for (int m = 0; m <= n; m++) begin
                stage_mirror[m] = {smp, 8'h00};
            end
        end else begin
            f  = 64'(inv_gain_reg) * 64'(count_mirror);
            d  = 64'd65536 + f;
            g  = ((64'd1 << 48) + (d >> 1)) / d;
            gc = (64'd1 << 32) - g;
            stage_mirror[0] = {smp, 8'h00};
            for (int m = 1; m <= n; m++) begin
                mix = to_offset(stage_mirror[m]) * gc + to_offset(stage_mirror[m-1]) * g
                    + (64'd1 << 31);
                stage_mirror[m] = mix[55:32] ^ 24'h800000;
            end
        end
        if (count_mirror != '1) begin
            count_mirror = count_mirror + 1'b1;
        end
        r = (to_offset(stage_mirror[n]) + 64'd128) >> 8;
        if (r > 64'd65535) begin
            r = 64'd65535;
        end
        cascade_predict = r[15:0] ^ 16'h8000;
    endfunction

    // called and returns at a falling edge
    task automatic send_sample(input logic [15:0] smp, input logic rst_cnt);
        int gap;
        gap = draw_gap(tx_mode);
        repeat (gap) @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tdata  = smp;
        s_tuser  = rst_cnt;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_filtered.push_back(cascade_predict(smp, rst_cnt));
        samples_sent++;
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(input logic [ofc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ofc_pkg::CFG_DAT_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == ofc_pkg::REG_LEVELS) begin
            levels_reg = val[ofc_pkg::LVL_W-1:0];
        end else begin
            inv_gain_reg = val[ofc_pkg::IG_W-1:0];
        end
        reg_writes++;
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_filtered.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // result checker with random and requested stalls
    initial begin
        logic [15:0] want;
        int          stall;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_tready = 1'b0;
                repeat (RX_HOLD) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            stall = draw_gap(rx_mode);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            results_checked++;
            if (expected_filtered.size() == 0) begin
                $error("unexpected result: filtered %0d", $signed(o_m_axis_tdata));
                error_count++;
            end else begin
                want = expected_filtered.pop_front();
                if (o_m_axis_tdata !== want) begin
                    $error("filtered mismatch: expected %0d, actual %0d",
                           $signed(want), $signed(o_m_axis_tdata));
                    error_count++;
                end
            end
        end
    end

    // seeding after reset and sample extremes at the reset settings
    task automatic test_seed_and_extremes();
        tx_mode = 1;
        rx_mode = 1;
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd1000, 1'b0);
    endtask

    // zero levels, capped levels, zero and oversized gain, restart, level change in mid-stream
    task automatic test_special_settings();
        wait_drained();
        write_reg(ofc_pkg::REG_LEVELS, '0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'd12345, 1'b0);
        wait_drained();
        write_reg(ofc_pkg::REG_LEVELS, 17'd31);
        write_reg(ofc_pkg::REG_INV_GAIN, '0);
        send_sample(16'd500, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        wait_drained();
        write_reg(ofc_pkg::REG_LEVELS, 17'd16);
        write_reg(ofc_pkg::REG_INV_GAIN, 17'h1FFFF);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'd7, 1'b0);
        wait_drained();
        write_reg(ofc_pkg::REG_INV_GAIN, 17'd65536);
        send_sample(16'h0F0F, 1'b0);
        send_sample(16'hF0F0, 1'b0);
        wait_drained();
        write_reg(ofc_pkg::REG_LEVELS, 17'd2);
        write_reg(ofc_pkg::REG_INV_GAIN, 17'd25000);
        send_sample(16'd100, 1'b1);
        send_sample(16'd200, 1'b0);
        wait_drained();
        // upper stages keep their older contents
        write_reg(ofc_pkg::REG_LEVELS, 17'd8);
        send_sample(16'd300, 1'b0);
        send_sample(-16'sd300, 1'b0);
    endtask

    // output held off for a long stretch while input keeps coming
    task automatic test_output_backpressure();
        wait_drained();
        write_reg(ofc_pkg::REG_LEVELS, 17'd16);
        write_reg(ofc_pkg::REG_INV_GAIN, 17'($urandom_range(5000, 40000)));
        rx_hold_req = 1'b1;
        tx_mode     = 0;
        rx_mode     = 0;
        for (int k = 0; k < 12; k++) begin
            send_sample(16'($urandom()), k == 0);
        end
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0: pick_sample = 16'sh8000;
            1: pick_sample = 16'sh7FFF;
            2: pick_sample = 16'($urandom_range(0, 511)) - 16'd256;
            default: pick_sample = 16'($urandom());
        endcase
    endfunction

    function automatic logic [ofc_pkg::CFG_DAT_W-1:0] pick_levels();
        case ($urandom_range(0, 9))
            0: pick_levels = '0;
            1: pick_levels = 17'($urandom_range(17, 31));
            2: pick_levels = 17'd16;
            3: pick_levels = 17'd1;
            default: pick_levels = 17'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [ofc_pkg::CFG_DAT_W-1:0] pick_inv_gain();
        case ($urandom_range(0, 7))
            0: pick_inv_gain = '0;
            1: pick_inv_gain = 17'h1FFFF;
            2: pick_inv_gain = 17'd65536;
            3: pick_inv_gain = 17'($urandom_range(0, 131071));
            default: pick_inv_gain = 17'($urandom_range(2000, 50000));
        endcase
    endfunction

    // random settings per phase, streams with occasional restarts
    task automatic test_random_streams(input int n_samples);
        int seg;
        int sent;
        sent = 0;
        while (sent < n_samples) begin
            wait_drained();
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);
            if ($urandom_range(0, 3) != 0) begin
                write_reg(ofc_pkg::REG_LEVELS, pick_levels());
            end
            if ($urandom_range(0, 3) != 0) begin
                write_reg(ofc_pkg::REG_INV_GAIN, pick_inv_gain());
            end
            seg = $urandom_range(20, 60);
            for (int k = 0; k < seg && sent < n_samples; k++) begin
                send_sample(pick_sample(), $urandom_range(0, 29) == 0);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        samples_sent    = 0;
        results_checked = 0;
        reg_writes      = 0;
        error_count     = 0;
        tx_mode         = 1;
        rx_mode         = 1;
        rx_hold_req     = 1'b0;
        levels_reg      = ofc_pkg::LEVELS_RESET;
        inv_gain_reg    = ofc_pkg::INV_GAIN_RESET;
        count_mirror    = '0;
        for (int m = 0; m <= MAX_LVL; m++) begin
            stage_mirror[m] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_seed_and_extremes();
        test_special_settings();
        test_output_backpressure();
        test_random_streams(620);

        wait_drained();
        $display("run covered %0d samples, %0d results checked, %0d register writes",
                 samples_sent, results_checked, reg_writes);
        $display("levels 0 to 31, gains 0 to 2^17-1, restarts and a long output stall");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("run timed out");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ofc_pkg.sv
rtl/core/ofc_ctrl.sv
rtl/core/ofc_dpath.sv
rtl/core/optimal_filtration_cascade.sv
tb/sv/tb_optimal_filtration_cascade.sv
